>>> rtl/core/switch_mode_controller_assert.svh
// Assertion macros used by the switch mode controller checker.
`ifndef SWITCH_MODE_CONTROLLER_ASSERT_SVH
`define SWITCH_MODE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SMC_ASSERT_SAME(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SMC_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

>>> rtl/core/smc_pkg.sv
// Types and constants of the switch mode controller.
package smc_pkg;

   localparam int MODE_W = 3;
   localparam int LEVEL_W = 8;
   localparam int HOLD_W = 8;
   localparam int TURBO_W = 16;
   localparam int LOWCNT_W = 3;

   typedef logic [MODE_W-1:0] mode_type;
   typedef logic [LEVEL_W-1:0] level_type;

   // Request kinds carried in req_tuser
   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_LOAD = 1'b1;

   // Configuration register indexes
   localparam logic [2:0] CSR_LOW_TO_HIGH   = 3'd0;
   localparam logic [2:0] CSR_MEMORY_ENABLE = 3'd1;
   localparam logic [2:0] CSR_LONG_PRESS    = 3'd2;
   localparam logic [2:0] CSR_TURBO_TIMEOUT = 3'd3;
   localparam logic [2:0] CSR_ADC_LOW       = 3'd4;
   localparam logic [2:0] CSR_ADC_CRIT      = 3'd5;
   localparam logic [2:0] CSR_ADC_DELAY     = 3'd6;

   // Register reset values
   localparam logic [HOLD_W-1:0]  LONG_PRESS_RESET    = 8'd32;
   localparam logic [TURBO_W-1:0] TURBO_TIMEOUT_RESET = 16'd5625;
   localparam logic [7:0]         ADC_LOW_RESET       = 8'd130;
   localparam logic [7:0]         ADC_CRIT_RESET      = 8'd120;
   localparam logic [7:0]         ADC_DELAY_RESET     = 8'd188;

   // Limits
   localparam logic [HOLD_W-1:0]   HOLD_MAX       = '1;
   localparam logic [TURBO_W-1:0]  TURBO_MAX      = '1;
   localparam logic [LOWCNT_W-1:0] LOWCNT_MAX     = '1;
   localparam logic [LOWCNT_W-1:0] LOW_READS_STEP = 3'd4;
   localparam level_type           TURBO_LEVEL    = 8'd255;

   // Fixed brightness table, padded with the top level
   function automatic level_type level_of(input mode_type m);
      case (m)
         3'd0:    return 8'd8;
         3'd1:    return 8'd14;
         3'd2:    return 8'd39;
         3'd3:    return 8'd125;
         default: return TURBO_LEVEL;
      endcase
   endfunction

endpackage

>>> rtl/core/switch_mode_controller.sv
// Switch mode controller: one request item (tick or load) in, one mode/level result out.
// A result is registered and shown in the cycle after its item is accepted.
// Throughput: one item per cycle while results are taken; all tick work is one pass of logic from the
// state registers into the result register, which frees as the result is taken.
// Reset (synchronous, active high) clears the state, restores the register
// defaults and empties the result register.
module switch_mode_controller
   import smc_pkg::*;
#(
   parameter int NUM_MODES        = 5,
   parameter int DEBOUNCE_SAMPLES = 4
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: switch_pressed[0], adc_ready[1], adc_value[9:2], load_index[12:10]
   input  logic [15:0] req_tdata,
   // tuser: req_type[0]
   input  logic        req_tuser,
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: mode_index[2:0], pwm_level[10:3], save_request[11], adc_restart[12]
   output logic [15:0] rsp_tdata,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam logic [MODE_W:0] MODE_COUNT = (MODE_W+1)'(NUM_MODES);
   localparam mode_type        TOP_MODE   = MODE_W'(NUM_MODES - 1);

   // configuration registers
   logic               low_to_high_ff;
   logic               memory_enable_ff;
   logic [HOLD_W-1:0]  long_press_ff;
   logic [TURBO_W-1:0] turbo_timeout_ff;
   logic [7:0]         adc_low_ff;
   logic [7:0]         adc_crit_ff;
   logic [7:0]         adc_delay_ff;

   // tick state
   logic [DEBOUNCE_SAMPLES-1:0] hist_ff, hist_in;
   logic [HOLD_W-1:0]           hold_ff, hold_in;
   mode_type                    mode_ff, mode_in;
   logic [TURBO_W-1:0]          turbo_ff, turbo_in;
   logic [7:0]                  delay_ff, delay_in;
   logic [LOWCNT_W-1:0]         lowcnt_ff, lowcnt_in;

   // result register
   logic        rsp_valid_ff;
   logic [15:0] rsp_data_ff, rsp_data_in;

   logic                      accept;
   logic                      sw_sample;
   logic                      adc_ready;
   logic [7:0]                adc_value;
   mode_type                  load_index;
   logic [DEBOUNCE_SAMPLES:0] hist_shift;
   mode_type                  load_mode;
   logic                      save_req;
   logic                      adc_restart;

   function automatic mode_type mode_up(input mode_type m);
      logic [MODE_W:0] nxt;
      nxt = {1'b0, m} + 1'b1;
      return (nxt >= MODE_COUNT) ? '0 : nxt[MODE_W-1:0];
   endfunction

   function automatic mode_type mode_down(input mode_type m);
      return (m == '0) ? TOP_MODE : m - 1'b1;
   endfunction

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign csr_ready  = !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // request fields
   assign sw_sample  = req_tdata[0];
   assign adc_ready  = req_tdata[1];
   assign adc_value  = req_tdata[9:2];
   assign load_index = req_tdata[12:10];
   assign hist_shift = {hist_ff, sw_sample};
   assign load_mode  = ({1'b0, load_index} >= MODE_COUNT) ? TOP_MODE : load_index;

   // next state and result for one item
   always_comb begin
      hist_in     = hist_ff;
      hold_in     = hold_ff;
      mode_in     = mode_ff;
      turbo_in    = turbo_ff;
      delay_in    = delay_ff;
      lowcnt_in   = lowcnt_ff;
      save_req    = 1'b0;
      adc_restart = 1'b0;
      if (req_tuser == REQ_LOAD) begin
         mode_in = load_mode;
      end else begin
         hist_in = hist_shift[DEBOUNCE_SAMPLES-1:0];
         if (hist_in != '0) begin
            // held: long press fires once when the hold count hits the threshold
            if (hold_ff != HOLD_MAX) begin
               hold_in = hold_ff + 1'b1;
               if (hold_in == long_press_ff) begin
                  mode_in  = low_to_high_ff ? mode_down(mode_ff) : mode_up(mode_ff);
                  save_req = memory_enable_ff;
               end
            end
            turbo_in = '0;
            delay_in = adc_delay_ff;
         end else begin
            if (hold_ff != '0 && hold_ff < long_press_ff) begin
               // short press on release
               mode_in  = low_to_high_ff ? mode_up(mode_ff) : mode_down(mode_ff);
               save_req = memory_enable_ff;
            end else begin
               // turbo timer
               if (level_of(mode_ff) == TURBO_LEVEL) begin
                  if (turbo_ff != TURBO_MAX) turbo_in = turbo_ff + 1'b1;
                  if (turbo_in > turbo_timeout_ff) mode_in = mode_down(mode_ff);
               end
               // battery check
               if (mode_in != '0) begin
                  if (delay_ff != '0) delay_in = delay_ff - 1'b1;
                  if (delay_in == '0) begin
                     if (adc_ready) begin
                        if (adc_value < ((mode_in == MODE_W'(1)) ? adc_crit_ff : adc_low_ff))
                        begin
                           if (lowcnt_ff != LOWCNT_MAX) lowcnt_in = lowcnt_ff + 1'b1;
                        end else begin
                           lowcnt_in = '0;
                        end
                     end
                     if (lowcnt_in >= LOW_READS_STEP) begin
                        mode_in   = mode_down(mode_in);
                        lowcnt_in = '0;
                        delay_in  = adc_delay_ff;
                     end
                     adc_restart = 1'b1;
                  end
               end
            end
            hold_in = '0;
         end
      end
      rsp_data_in = {3'b000, adc_restart, save_req, level_of(mode_in), mode_in};
   end

   // configuration, state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         low_to_high_ff   <= 1'b0;
         memory_enable_ff <= 1'b0;
         long_press_ff    <= LONG_PRESS_RESET;
         turbo_timeout_ff <= TURBO_TIMEOUT_RESET;
         adc_low_ff       <= ADC_LOW_RESET;
         adc_crit_ff      <= ADC_CRIT_RESET;
         adc_delay_ff     <= ADC_DELAY_RESET;
         hist_ff          <= '0;
         hold_ff          <= '0;
         mode_ff          <= '0;
         turbo_ff         <= '0;
         delay_ff         <= ADC_DELAY_RESET;
         lowcnt_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LOW_TO_HIGH:   low_to_high_ff   <= csr_data[0];
               CSR_MEMORY_ENABLE: memory_enable_ff <= csr_data[0];
               CSR_LONG_PRESS:    long_press_ff    <= csr_data[7:0];
               CSR_TURBO_TIMEOUT: turbo_timeout_ff <= csr_data;
               CSR_ADC_LOW:       adc_low_ff       <= csr_data[7:0];
               CSR_ADC_CRIT:      adc_crit_ff      <= csr_data[7:0];
               CSR_ADC_DELAY:     adc_delay_ff     <= csr_data[7:0];
               default:           ;
            endcase
         end
         if (accept) begin
            hist_ff   <= hist_in;
            hold_ff   <= hold_in;
            mode_ff   <= mode_in;
            turbo_ff  <= turbo_in;
            delay_ff  <= delay_in;
            lowcnt_ff <= lowcnt_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

>>> rtl/core/smc_checker.sv
// Port-level checker for the switch mode controller, bound to the top level.
`include "switch_mode_controller_assert.svh"

module smc_checker
   import smc_pkg::*;
#(
   parameter int NUM_MODES = 5
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   localparam logic [MODE_W:0] MODE_COUNT = (MODE_W+1)'(NUM_MODES);

   logic     stalled;
   mode_type rsp_mode;

   assign stalled  = rsp_tvalid && !rsp_tready;
   assign rsp_mode = rsp_tdata[2:0];

   // every accepted item shows a result in the next cycle
   `SMC_ASSERT_NEXT(a_item_gives_result, clock, reset, req_tvalid && req_tready, rsp_tvalid, "accepted item gave no result")

   // a waiting result blocks new items
   `SMC_ASSERT_SAME(a_stall_blocks_input, clock, reset, stalled, !req_tready, "item taken while result stalled")

   // level matches the mode, and the mode stays in range
   `SMC_ASSERT_SAME(a_level_matches_mode, clock, reset, rsp_tvalid, (rsp_tdata[10:3] == level_of(rsp_mode)) && ({1'b0, rsp_mode} < MODE_COUNT), "bad mode or level")

   // a press never coincides with a battery check
   `SMC_ASSERT_SAME(a_save_excludes_restart, clock, reset, rsp_tvalid, !(rsp_tdata[11] && rsp_tdata[12]), "save and restart together")

   // stalled result holds
   `SMC_ASSERT_NEXT(a_stall_holds, clock, reset, stalled, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

endmodule

bind switch_mode_controller smc_checker #(.NUM_MODES(NUM_MODES)) u_smc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> sim/tb.sv
// Self-checking testbench for the switch mode controller, with a predictor and random traffic.
module tb
   import smc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MODES       = 5;
   localparam int HISTORY_LEN = 4;
   localparam int LOW_STEP    = 4;
   localparam int LIMIT       = 500000;
   localparam int PHASE_ITEMS = 270;

   // one request item as the sender sees it
   typedef struct packed {
      logic       req_type;
      logic [2:0] load_index;
      logic [7:0] adc_value;
      logic       adc_ready;
      logic       switch_pressed;
   } req_item_type;

   // one result item, laid out as rsp_tdata[12:0]
   typedef struct packed {
      logic      adc_restart;
      logic      save_request;
      level_type pwm_level;
      mode_type  mode_index;
   } mode_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   switch_mode_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor copy of the registers
   logic        cfg_short_up     = 1'b0;
   logic        cfg_save_en      = 1'b0;
   logic [7:0]  cfg_long_ticks   = LONG_PRESS_RESET;
   logic [15:0] cfg_turbo_limit  = TURBO_TIMEOUT_RESET;
   logic [7:0]  cfg_batt_low     = ADC_LOW_RESET;
   logic [7:0]  cfg_batt_crit    = ADC_CRIT_RESET;
   logic [7:0]  cfg_check_period = ADC_DELAY_RESET;

   // predictor copy of the light state
   logic [HISTORY_LEN-1:0] sw_history  = '0;
   logic [7:0]             held_ticks  = '0;
   mode_type               cur_mode    = '0;
   logic [15:0]            turbo_idle  = '0;
   logic [7:0]             check_wait  = ADC_DELAY_RESET;
   logic [2:0]             low_reads   = '0;

   level_type brightness [8] = '{8'd8, 8'd14, 8'd39, 8'd125, 8'd255, 8'd255, 8'd255, 8'd255};

   req_item_type    pending_items [$];
   mode_result_type expected_modes [$];
   req_item_type    cur_item;
   int              mismatches = 0;
   int              cycles = 0;
   logic            steady_flow = 1'b0;

   function automatic mode_type ring_up(mode_type m);
      return (m == MODES - 1) ? mode_type'(0) : mode_type'(m + 1);
   endfunction

   function automatic mode_type ring_down(mode_type m);
      return (m == 0) ? mode_type'(MODES - 1) : mode_type'(m - 1);
   endfunction

   // advance the light state by one item and return what the block should show
   function automatic mode_result_type step_light(req_item_type it);
      mode_result_type r;
      logic [7:0]      thr;
      r = '0;
      if (it.req_type == REQ_LOAD) begin
         cur_mode = (it.load_index >= MODES) ? mode_type'(MODES - 1) : it.load_index;
      end else begin
         sw_history = {sw_history[HISTORY_LEN-2:0], it.switch_pressed};
         if (sw_history != 0) begin
            // switch held: count, fire the long press once
            if (held_ticks != 8'hFF) begin
               held_ticks++;
               if (held_ticks == cfg_long_ticks) begin
                  cur_mode = cfg_short_up ? ring_down(cur_mode) : ring_up(cur_mode);
                  r.save_request = cfg_save_en;
               end
            end
            turbo_idle = '0;
            check_wait = cfg_check_period;
         end else begin
            if (held_ticks > 0 && held_ticks < cfg_long_ticks) begin
               // released before the long threshold
               cur_mode = cfg_short_up ? ring_up(cur_mode) : ring_down(cur_mode);
               r.save_request = cfg_save_en;
            end else begin
               // idle: turbo timer, then battery check
               if (brightness[cur_mode] == 8'd255) begin
                  if (turbo_idle != 16'hFFFF) turbo_idle++;
                  if (turbo_idle > cfg_turbo_limit) cur_mode = ring_down(cur_mode);
               end
               if (cur_mode > 0) begin
                  if (check_wait > 0) check_wait--;
                  if (check_wait == 0) begin
                     if (it.adc_ready) begin
                        thr = (cur_mode == 1) ? cfg_batt_crit : cfg_batt_low;
                        if (it.adc_value < thr) begin
                           if (low_reads != 3'd7) low_reads++;
                        end else begin
                           low_reads = '0;
                        end
                     end
                     if (low_reads >= LOW_STEP) begin
                        cur_mode = ring_down(cur_mode);
                        low_reads = '0;
                        check_wait = cfg_check_period;
                     end
                     r.adc_restart = 1'b1;
                  end
               end
            end
            held_ticks = '0;
         end
      end
      r.mode_index = cur_mode;
      r.pwm_level = brightness[cur_mode];
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) expected_modes.push_back(step_light(cur_item));
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() != 0 && (steady_flow || $urandom_range(0, 99) >= 14)) begin
               cur_item = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {3'b000, cur_item.load_index, cur_item.adc_value,
                             cur_item.adc_ready, cur_item.switch_pressed};
               req_tuser <= cur_item.req_type;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      mode_result_type seen;
      mode_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata[12:0];
            if (expected_modes.size() == 0) begin
               $error("result item with nothing expected: %h", rsp_tdata);
               mismatches++;
            end else begin
               want = expected_modes.pop_front();
               if (seen.mode_index !== want.mode_index) begin
                  $error("mode_index: expected %0d, got %0d", want.mode_index, seen.mode_index);
                  mismatches++;
               end
               if (seen.pwm_level !== want.pwm_level) begin
                  $error("pwm_level: expected %0d, got %0d", want.pwm_level, seen.pwm_level);
                  mismatches++;
               end
               if (seen.save_request !== want.save_request) begin
                  $error("save_request: expected %0d, got %0d",
                         want.save_request, seen.save_request);
                  mismatches++;
               end
               if (seen.adc_restart !== want.adc_restart) begin
                  $error("adc_restart: expected %0d, got %0d",
                         want.adc_restart, seen.adc_restart);
                  mismatches++;
               end
            end
         end
         rsp_tready <= steady_flow || $urandom_range(0, 99) >= 14;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   task automatic queue_item(logic kind, logic sw, logic rdy, logic [7:0] adc, logic [2:0] idx);
      req_item_type it;
      it.req_type = kind;
      it.switch_pressed = sw;
      it.adc_ready = rdy;
      it.adc_value = adc;
      it.load_index = idx;
      pending_items.push_back(it);
   endtask

   // battery reading, biased toward the thresholds
   function automatic logic [7:0] battery_sample(logic sagging);
      if (sagging) return 8'($urandom_range(0, 15));
      case ($urandom_range(0, 4))
         0: return 8'(cfg_batt_low + $urandom_range(0, 2) - 1);
         1: return 8'(cfg_batt_crit + $urandom_range(0, 2) - 1);
         2: return 8'h00;
         3: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // press with a little contact bounce, then a release long enough to settle
   task automatic queue_press();
      int n;
      int lp;
      lp = cfg_long_ticks;
      if ($urandom_range(0, 3) == 0) n = lp + $urandom_range(0, 3);
      else n = $urandom_range(1, (lp > 8) ? 8 : lp);
      for (int i = 0; i < n; i++)
         queue_item(REQ_TICK, (i == 0) || ($urandom_range(0, 9) != 0), 1'($urandom_range(0, 1)),
                    battery_sample(1'b0), 3'($urandom_range(0, 7)));
      repeat ($urandom_range(4, 8))
         queue_item(REQ_TICK, 1'b0, 1'($urandom_range(0, 1)), battery_sample(1'b0),
                    3'($urandom_range(0, 7)));
   endtask

   // switch idle, battery readings coming in
   task automatic queue_idle();
      int   n;
      logic sagging;
      sagging = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 9) == 0) n = $urandom_range(cfg_check_period, cfg_check_period + 20);
      else n = $urandom_range(1, 25);
      repeat (n)
         queue_item(REQ_TICK, 1'b0, $urandom_range(0, 3) != 0, battery_sample(sagging),
                    3'($urandom_range(0, 7)));
   endtask

   task automatic queue_random(int target);
      req_item_type it;
      int           start;
      start = pending_items.size();
      while (pending_items.size() - start < target) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8: queue_press();
            9, 10, 11, 12, 13, 14: queue_idle();
            15, 16:
               queue_item(REQ_LOAD, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255)),
                          ($urandom_range(0, 1) != 0) ? 3'd4 : 3'($urandom_range(0, 7)));
            default: begin
               it = req_item_type'($urandom);
               it.req_type = ($urandom_range(0, 7) == 0) ? REQ_LOAD : REQ_TICK;
               pending_items.push_back(it);
            end
         endcase
      end
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || req_tvalid || expected_modes.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_LOW_TO_HIGH:   cfg_short_up = val[0];
         CSR_MEMORY_ENABLE: cfg_save_en = val[0];
         CSR_LONG_PRESS:    cfg_long_ticks = val[7:0];
         CSR_TURBO_TIMEOUT: cfg_turbo_limit = val;
         CSR_ADC_LOW:       cfg_batt_low = val[7:0];
         CSR_ADC_CRIT:      cfg_batt_crit = val[7:0];
         CSR_ADC_DELAY:     cfg_check_period = val[7:0];
         default: ;
      endcase
   endtask

   task automatic set_up(int lth, int mem, int lp, int tt, int lo, int crit, int dly);
      write_csr(CSR_LOW_TO_HIGH, 16'(lth));
      write_csr(CSR_MEMORY_ENABLE, 16'(mem));
      write_csr(CSR_LONG_PRESS, 16'(lp));
      write_csr(CSR_TURBO_TIMEOUT, 16'(tt));
      write_csr(CSR_ADC_LOW, 16'(lo));
      write_csr(CSR_ADC_CRIT, 16'(crit));
      write_csr(CSR_ADC_DELAY, 16'(dly));
      @(negedge clock);
   endtask

   // stimulus sequence
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register defaults
      queue_random(PHASE_ITEMS);
      wait_drained();

      // lowest thresholds, critical battery level at the top: every press is long, turbo drops at once
      set_up(1, 1, 1, 0, 0, 255, 1);
      queue_item(REQ_LOAD, 1'b0, 1'b0, 8'h00, 3'd7);
      queue_item(REQ_LOAD, 1'b1, 1'b1, 8'hFF, 3'd5);
      queue_item(REQ_LOAD, 1'b0, 1'b0, 8'h00, 3'd6);
      queue_item(REQ_LOAD, 1'b0, 1'b0, 8'h00, 3'd0);
      queue_item(REQ_LOAD, 1'b0, 1'b0, 8'h00, 3'd3);
      queue_item(REQ_TICK, 1'b1, 1'b1, 8'hFF, 3'd0);
      queue_item(REQ_TICK, 1'b1, 1'b0, 8'h00, 3'd0);
      repeat (4) queue_item(REQ_TICK, 1'b0, 1'b1, 8'h00, 3'd0);
      queue_item(REQ_LOAD, 1'b0, 1'b0, 8'h00, 3'd1);
      // sustained low battery in mode one
      repeat (4) queue_item(REQ_TICK, 1'b0, 1'b1, 8'h00, 3'd0);
      queue_item(REQ_LOAD, 1'b0, 1'b0, 8'h00, 3'd4);
      queue_item(REQ_TICK, 1'b0, 1'b0, 8'hFF, 3'd0);
      queue_item(REQ_LOAD, 1'b0, 1'b0, 8'h00, 3'd2);
      queue_item(REQ_TICK, 1'b1, 1'b1, 8'hFF, 3'd7);
      queue_random(PHASE_ITEMS);
      wait_drained();

      // highest thresholds, critical battery level at the bottom
      set_up(0, 1, 254, 65534, 255, 0, 255);
      queue_random(PHASE_ITEMS);
      wait_drained();

      // typical settings, no idling on either side
      set_up($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(2, 10),
             $urandom_range(0, 40), $urandom_range(100, 200), $urandom_range(90, 150),
             $urandom_range(1, 12));
      steady_flow = 1'b1;
      queue_random(PHASE_ITEMS);
      wait_drained();
      steady_flow = 1'b0;

      repeat (2) begin
         set_up($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(2, 10),
                $urandom_range(0, 40), $urandom_range(100, 200), $urandom_range(90, 150),
                $urandom_range(1, 12));
         queue_random(PHASE_ITEMS);
         wait_drained();
      end

      if (mismatches == 0 && expected_modes.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

>>> switch_mode_controller.f
+incdir+rtl/core
rtl/core/smc_pkg.sv
rtl/core/switch_mode_controller.sv
rtl/core/smc_checker.sv
sim/tb.sv
